/* rtl/core/cartridge_bank_mapper_with_unlock_defines.svh */
// assertion helpers for the cartridge bank mapper
`ifndef CARTRIDGE_BANK_MAPPER_WITH_UNLOCK_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_UNLOCK_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CBM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CBM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/cbm_pkg.sv */
package cbm_pkg;

	localparam int ROM_ADDR_BITS_DEF      = 22;
	localparam int UNLOCK_TRANSITIONS_DEF = 48;

	localparam int MEM_ADDR_W = 22;
	localparam int CPU_ADDR_W = 16;
	localparam int BYTE_W     = 8;
	localparam int COUNT_W    = 6;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_LSB = 2;

	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	typedef enum logic [1:0] {
		REGION_ROM  = 2'd0,
		REGION_RAM  = 2'd1,
		REGION_PASS = 2'd2,
		REGION_NONE = 2'd3
	} region_t;

	typedef enum logic {
		REG_BOOTSTRAP = 1'b0,
		REG_ROM_MASK  = 1'b1
	} reg_index_t;

	// write window select, cpu_address[15:13]
	typedef enum logic [2:0] {
		WIN_OUTER_BANK = 3'd0,
		WIN_INNER_BANK = 3'd1,
		WIN_OUTER_MASK = 3'd2,
		WIN_RAM        = 3'd5
	} win_t;

	localparam logic [7:0] HEADER_PAGE = 8'h01;
	localparam logic [CPU_ADDR_W-1:0] UNLOCK_ADDR = 16'h0100;

	typedef struct packed {
		logic                  bootstrap_mode;
		logic [MEM_ADDR_W-1:0] rom_address_mask;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  outer_bank;
		logic [BYTE_W-1:0]  outer_mask;
		logic [BYTE_W-1:0]  inner_bank;
		logic               lock_flag;
		logic [COUNT_W-1:0] unlock_count;
	} bank_state_t;

	typedef struct packed {
		region_t               region;
		logic [MEM_ADDR_W-1:0] mem_address;
		logic                  ram_write;
		logic [BYTE_W-1:0]     ram_byte;
		logic                  unlocked_now;
	} result_t;

	// header scramble: exchange bits 0<->6 and 1<->4
	function automatic logic [CPU_ADDR_W-1:0] header_swap(input logic [CPU_ADDR_W-1:0] a);
		logic [CPU_ADDR_W-1:0] r;
		r    = a;
		r[0] = a[6];
		r[1] = a[4];
		r[4] = a[1];
		r[6] = a[0];
		return r;
	endfunction

endpackage

/* rtl/core/cbm_apb_regs.sv */
module cbm_apb_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cbm_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [cbm_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [cbm_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready,
	output cbm_pkg::cfg_t                  cfg
);
	import cbm_pkg::*;

	cfg_t       cfg_q;
	reg_index_t idx;
	logic       wr_en;

	assign idx    = reg_index_t'(paddr[CFG_IDX_LSB]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bootstrap_mode   <= 1'b0;
			cfg_q.rom_address_mask <= {MEM_ADDR_W{1'b1}};
		end else if (wr_en) begin
			unique case (idx)
				REG_BOOTSTRAP: cfg_q.bootstrap_mode   <= pwdata[0];
				REG_ROM_MASK:  cfg_q.rom_address_mask <= pwdata[MEM_ADDR_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_BOOTSTRAP: prdata = {{(CFG_DATA_W-1){1'b0}}, cfg_q.bootstrap_mode};
			REG_ROM_MASK:  prdata = {{(CFG_DATA_W-MEM_ADDR_W){1'b0}}, cfg_q.rom_address_mask};
		endcase
	end

	assign cfg = cfg_q;

endmodule

/* rtl/core/cbm_xlate.sv */
module cbm_xlate #(
	parameter int ROM_ADDR_BITS      = cbm_pkg::ROM_ADDR_BITS_DEF,
	parameter int UNLOCK_TRANSITIONS = cbm_pkg::UNLOCK_TRANSITIONS_DEF
) (
	input  logic                           kind,
	input  logic [cbm_pkg::CPU_ADDR_W-1:0] cpu_address,
	input  logic [cbm_pkg::BYTE_W-1:0]     write_byte,
	input  cbm_pkg::cfg_t                  cfg,
	input  cbm_pkg::bank_state_t           cur,
	output cbm_pkg::bank_state_t           nxt,
	output cbm_pkg::result_t               res
);
	import cbm_pkg::*;

	localparam logic [MEM_ADDR_W-1:0] ROM_WIDTH_MASK =
		MEM_ADDR_W'((23'(1) << ROM_ADDR_BITS) - 23'(1));
	localparam logic [COUNT_W-1:0] UNLOCK_CNT = COUNT_W'(UNLOCK_TRANSITIONS);

	logic                  open;
	logic [BYTE_W-1:0]     low_bank;
	logic [BYTE_W-1:0]     high_bank;
	logic [CPU_ADDR_W-1:0] a;
	logic [MEM_ADDR_W-1:0] base;

	assign open      = &cur.inner_bank[5:4];
	assign low_bank  = cur.outer_bank & cur.outer_mask;
	assign high_bank = low_bank | (cur.inner_bank & ~cur.outer_mask);

	always_comb begin
		nxt              = cur;
		res.region       = REGION_NONE;
		res.mem_address  = '0;
		res.ram_write    = 1'b0;
		res.ram_byte     = '0;
		res.unlocked_now = 1'b0;
		a                = cpu_address;
		base             = '0;
		if (kind == KIND_WRITE) begin
			unique case (cpu_address[15:13])
				WIN_OUTER_BANK: if (open) nxt.outer_bank = write_byte;
				WIN_INNER_BANK: nxt.inner_bank = (write_byte != '0) ? write_byte : BYTE_W'(1);
				WIN_OUTER_MASK: if (open) nxt.outer_mask = write_byte;
				WIN_RAM: begin
					res.region      = REGION_RAM;
					res.mem_address = MEM_ADDR_W'(cpu_address[12:0]);
					res.ram_write   = 1'b1;
					res.ram_byte    = write_byte;
				end
				default: ;
			endcase
		end else begin
			// boot rom emulation: count rom reads, force bit 7 while locked
			if (cfg.bootstrap_mode) begin
				if (!cpu_address[15]) begin
					if (cur.unlock_count == UNLOCK_CNT) begin
						res.unlocked_now = cur.lock_flag;
						nxt.lock_flag    = 1'b0;
					end else begin
						nxt.unlock_count = cur.unlock_count + COUNT_W'(1);
					end
				end
				if (nxt.lock_flag) a[7] = 1'b1;
			end
			if (a[15:8] == HEADER_PAGE) a = header_swap(a);
			if (nxt.lock_flag && (a == UNLOCK_ADDR) && !cfg.bootstrap_mode) begin
				nxt.lock_flag    = 1'b0;
				res.unlocked_now = 1'b1;
			end
			priority if (a[15:14] == 2'b00) begin
				base            = {low_bank, 14'b0} & cfg.rom_address_mask & ROM_WIDTH_MASK;
				res.region      = REGION_ROM;
				res.mem_address = base | MEM_ADDR_W'(a[13:0]);
			end else if (a[15:14] == 2'b01) begin
				base            = {high_bank, 14'b0} & cfg.rom_address_mask & ROM_WIDTH_MASK;
				res.region      = REGION_ROM;
				res.mem_address = base | MEM_ADDR_W'(a[13:0]);
			end else if (a[15:13] == WIN_RAM) begin
				res.region      = REGION_RAM;
				res.mem_address = MEM_ADDR_W'(a[12:0]);
			end else begin
				res.region      = REGION_PASS;
				res.mem_address = MEM_ADDR_W'(a);
			end
		end
	end

endmodule

/* rtl/core/cbm_out_reg.sv */
module cbm_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  cbm_pkg::result_t res,
	input  logic             out_stall,
	output logic             out_valid,
	output cbm_pkg::result_t res_s1
);
	import cbm_pkg::*;

	logic valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (!out_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s1 <= res;
		end
	end

	assign out_valid = valid_s1;

endmodule

/* rtl/core/cartridge_bank_mapper_with_unlock.sv */
// results are registered: an access accepted at one edge shows its result after that edge
// throughput: one access per cycle while in_stall is low, set by the single output register stage
// in_stall rises only while a result waits and out_stall holds it
// reset (arst_n low, asynchronous): banks cleared, inner bank 1, locked, count 0,
// bootstrap off, rom mask all ones, output register empty
`include "cartridge_bank_mapper_with_unlock_defines.svh"

module cartridge_bank_mapper_with_unlock #(
	parameter int ROM_ADDR_BITS      = cbm_pkg::ROM_ADDR_BITS_DEF,
	parameter int UNLOCK_TRANSITIONS = cbm_pkg::UNLOCK_TRANSITIONS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// apb configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cbm_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [cbm_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [cbm_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready,
	// access channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           kind,
	input  logic [cbm_pkg::CPU_ADDR_W-1:0] cpu_address,
	input  logic [cbm_pkg::BYTE_W-1:0]     write_byte,
	// result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     region,
	output logic [cbm_pkg::MEM_ADDR_W-1:0] mem_address,
	output logic                           ram_write,
	output logic [cbm_pkg::BYTE_W-1:0]     ram_byte,
	output logic                           unlocked_now
);
	import cbm_pkg::*;

	cfg_t        cfg;
	bank_state_t state_q;
	bank_state_t state_nxt;
	result_t     res;
	result_t     res_s1;
	logic        in_accept;

	cbm_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// a new transaction may enter whenever the output slot is free or draining
	assign in_stall  = out_valid & out_stall;
	assign in_accept = in_valid & ~in_stall;

	// translation and next bank/lock state, all from the current registers
	cbm_xlate #(
		.ROM_ADDR_BITS      (ROM_ADDR_BITS),
		.UNLOCK_TRANSITIONS (UNLOCK_TRANSITIONS)
	) u_xlate (
		.kind        (kind),
		.cpu_address (cpu_address),
		.write_byte  (write_byte),
		.cfg         (cfg),
		.cur         (state_q),
		.nxt         (state_nxt),
		.res         (res)
	);

	// bank and lock state moves only on an accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.outer_bank   <= '0;
			state_q.outer_mask   <= '0;
			state_q.inner_bank   <= BYTE_W'(1);
			state_q.lock_flag    <= 1'b1;
			state_q.unlock_count <= '0;
		end else if (in_accept) begin
			state_q <= state_nxt;
		end
	end

	cbm_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_accept),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res_s1    (res_s1)
	);

	assign region       = res_s1.region;
	assign mem_address  = res_s1.mem_address;
	assign ram_write    = res_s1.ram_write;
	assign ram_byte     = res_s1.ram_byte;
	assign unlocked_now = res_s1.unlocked_now;

	// once unlocked the cartridge stays unlocked
	`CBM_ASSERT_NEXT(a_lock_sticky, !state_q.lock_flag, !state_q.lock_flag, "lock set again")
	// an unlock report always leaves the lock cleared
	`CBM_ASSERT_NEXT(a_unlock_clears, in_accept && res.unlocked_now, !state_q.lock_flag,
		"unlock reported but still locked")
	// the counter stops at the unlock count
	`CBM_ASSERT_NOW(a_count_range, 1'b1,
		state_q.unlock_count <= COUNT_W'(UNLOCK_TRANSITIONS), "unlock count overrun")
	// inner bank never holds zero
	`CBM_ASSERT_NOW(a_inner_nonzero, 1'b1, state_q.inner_bank != '0, "inner bank zero")

endmodule
